FILE: sv/fclm_pkg.sv
// ----------------------------------------------------------------------------
// fclm_pkg
// Shared types, codes and widths of the flow-to-CPU least-loaded mapper.
// ----------------------------------------------------------------------------
package fclm_pkg;

   localparam int TABLE_ENTRIES_DEF = 64;
   localparam int MAX_CPUS_DEF      = 16;

   localparam int OP_W       = 2;
   localparam int KEY_W      = 16;
   localparam int LOAD_W     = 16;
   localparam int CFG_W      = 5;
   localparam int OUT_CPU_W  = 4;
   localparam int STATUS_W   = 2;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 8;

   localparam logic [OP_W-1:0] OP_REGISTER   = 2'd0;
   localparam logic [OP_W-1:0] OP_LOOKUP     = 2'd1;
   localparam logic [OP_W-1:0] OP_UNREGISTER = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

   localparam logic [LOAD_W-1:0] LOAD_MAX        = '1;
   localparam logic [CFG_W-1:0]  CPU_COUNT_RESET = 5'd1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOAD_SCAN,
      S_CHARGE,
      S_KEY_SCAN,
      S_WRITE,
      S_DISC_RD,
      S_DISC_WR,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic start;
      logic load_scan;
      logic charge;
      logic key_scan;
      logic table_write;
      logic disc_read;
      logic disc_write;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic            load_done;
      logic            key_done;
      logic            hit;
      logic [OP_W-1:0] op;
   } sts_type;

endpackage

FILE: sv/flow_to_cpu_least_loaded_mapper.sv
// ----------------------------------------------------------------------------
// flow_to_cpu_least_loaded_mapper
// Maps flow keys to the least-loaded CPU and tracks per-CPU load counters.
// Register scans the load RAM, one entry per cycle over the N active CPUs,
// charges the least-loaded CPU and scans the F filled flow table entries;
// lookup and unregister scan only the flow table RAM, unregister then
// discharging the mapped CPU. One item at a time; the next item is taken
// while a result waits.
// Reset clears loads and table fill at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module flow_to_cpu_least_loaded_mapper #(
   parameter int TABLE_ENTRIES = fclm_pkg::TABLE_ENTRIES_DEF,
   parameter int MAX_CPUS      = fclm_pkg::MAX_CPUS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [fclm_pkg::REQ_DATA_W-1:0]   req_tdata,   // opcode, flow_key
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [fclm_pkg::RSP_DATA_W-1:0]   rsp_tdata,   // cpu, status
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [fclm_pkg::CFG_W-1:0]        csr_data     // cpu_count
);

   import fclm_pkg::*;

   cmd_type              cmd;
   sts_type              sts;
   logic [OP_W-1:0]      req_op;
   logic [KEY_W-1:0]     req_key;
   logic [OUT_CPU_W-1:0] rsp_cpu;
   logic [STATUS_W-1:0]  rsp_status;

   assign req_op    = req_tdata[OP_W-1:0];
   assign req_key   = req_tdata[OP_W+KEY_W-1:OP_W];
   assign csr_ready = 1'b1;
   assign rsp_tdata = {{(RSP_DATA_W-OUT_CPU_W-STATUS_W){1'b0}}, rsp_status, rsp_cpu};

   fclm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_op    (req_op),
      .req_ready (req_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .sts       (sts),
      .cmd       (cmd)
   );

   fclm_dp #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .MAX_CPUS      (MAX_CPUS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_op     (req_op),
      .req_key    (req_key),
      .csr_we     (csr_valid),
      .csr_data   (csr_data),
      .rsp_cpu    (rsp_cpu),
      .rsp_status (rsp_status)
   );

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> !(rsp_tvalid && !rsp_tready))
      else $error("result register overwritten while held");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("item accepted while previous item in flight");

   a_write_on_register: assert property (@(posedge clock) disable iff (reset)
      cmd.table_write |-> (sts.op == OP_REGISTER))
      else $error("table write outside register item");

   a_discharge_on_hit: assert property (@(posedge clock) disable iff (reset)
      cmd.disc_write |-> (sts.hit && sts.op == OP_UNREGISTER))
      else $error("discharge without mapped key");

endmodule

FILE: sv/fclm_ram.sv
// ----------------------------------------------------------------------------
// fclm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fclm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/fclm_ctrl.sv
// ----------------------------------------------------------------------------
// fclm_ctrl
// Sequencer of the mapper: walks each item through scan, update and response.
// ----------------------------------------------------------------------------
module fclm_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic [fclm_pkg::OP_W-1:0] req_op,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  fclm_pkg::sts_type     sts,
   output fclm_pkg::cmd_type     cmd
);

   import fclm_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_op == OP_REGISTER) begin
                  state_in = S_LOAD_SCAN;
               end else if (req_op == OP_LOOKUP || req_op == OP_UNREGISTER) begin
                  state_in = S_KEY_SCAN;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end
         S_LOAD_SCAN: begin
            if (sts.load_done) state_in = S_CHARGE;
         end
         S_CHARGE: state_in = S_KEY_SCAN;
         S_KEY_SCAN: begin
            if (sts.key_done) begin
               if (sts.op == OP_REGISTER) begin
                  state_in = S_WRITE;
               end else if (sts.op == OP_UNREGISTER && sts.hit) begin
                  state_in = S_DISC_RD;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end
         S_WRITE:   state_in = S_FINISH;
         S_DISC_RD: state_in = S_DISC_WR;
         S_DISC_WR: state_in = S_FINISH;
         S_FINISH: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            cmd.start = req_valid;
         end
         S_LOAD_SCAN: cmd.load_scan   = 1'b1;
         S_CHARGE:    cmd.charge      = 1'b1;
         S_KEY_SCAN:  cmd.key_scan    = 1'b1;
         S_WRITE:     cmd.table_write = 1'b1;
         S_DISC_RD:   cmd.disc_read   = 1'b1;
         S_DISC_WR:   cmd.disc_write  = 1'b1;
         S_FINISH:    cmd.rsp_load    = out_free;
         default:     cmd             = '0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: sv/fclm_dp.sv
// ----------------------------------------------------------------------------
// fclm_dp
// Datapath: load counters, flow table, scan counter and result register.
// ----------------------------------------------------------------------------
module fclm_dp #(
   parameter int TABLE_ENTRIES = fclm_pkg::TABLE_ENTRIES_DEF,
   parameter int MAX_CPUS      = fclm_pkg::MAX_CPUS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  fclm_pkg::cmd_type             cmd,
   output fclm_pkg::sts_type             sts,
   input  logic [fclm_pkg::OP_W-1:0]     req_op,
   input  logic [fclm_pkg::KEY_W-1:0]    req_key,
   input  logic                          csr_we,
   input  logic [fclm_pkg::CFG_W-1:0]    csr_data,
   output logic [fclm_pkg::OUT_CPU_W-1:0] rsp_cpu,
   output logic [fclm_pkg::STATUS_W-1:0] rsp_status
);

   import fclm_pkg::*;

   localparam int TAW      = TABLE_ENTRIES > 1 ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CW       = MAX_CPUS > 1 ? $clog2(MAX_CPUS) : 1;
   localparam int FILL_W   = $clog2(TABLE_ENTRIES + 1);
   localparam int SCAN_MAX = TABLE_ENTRIES > MAX_CPUS ? TABLE_ENTRIES : MAX_CPUS;
   localparam int CNT_W    = $clog2(SCAN_MAX + 1);
   localparam int ENT_W    = KEY_W + CW;

   logic [OP_W-1:0]     op_ff, op_in;
   logic [KEY_W-1:0]    key_ff, key_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                lrdv_ff, lrdv_in;
   logic                lrd_vld_ff, lrd_vld_in;
   logic [CW-1:0]       lrd_idx_ff, lrd_idx_in;
   logic                krdv_ff, krdv_in;
   logic [TAW-1:0]      krd_idx_ff, krd_idx_in;
   logic [CW-1:0]       best_ff, best_in;
   logic [LOAD_W:0]     best_load_ff, best_load_in;
   logic                hit_ff, hit_in;
   logic [TAW-1:0]      hit_idx_ff, hit_idx_in;
   logic [CW-1:0]       hit_cpu_ff, hit_cpu_in;
   logic                full_ff, full_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic                load_vld_ff [MAX_CPUS];
   logic                load_vld_in [MAX_CPUS];
   logic [CFG_W-1:0]    cpu_count_ff, cpu_count_in;
   logic [OUT_CPU_W-1:0] rsp_cpu_ff, rsp_cpu_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic [CNT_W-1:0]    act_n;
   logic                load_issue, key_issue, table_free;
   logic                load_rd_en, load_wr_en;
   logic [CW-1:0]       load_rd_addr, load_wr_addr;
   logic [LOAD_W-1:0]   load_q, load_val, load_wr_data;
   logic                tbl_wr_en;
   logic [TAW-1:0]      tbl_wr_addr;
   logic [ENT_W-1:0]    tbl_q;
   logic [31:0]         best_wide, hit_cpu_wide;

   always_comb begin
      if (cpu_count_ff == '0) begin
         act_n = CNT_W'(1);
      end else if (32'(cpu_count_ff) > 32'(MAX_CPUS)) begin
         act_n = CNT_W'(MAX_CPUS);
      end else begin
         act_n = CNT_W'(cpu_count_ff);
      end
   end

   assign load_issue   = cmd.load_scan && (cnt_ff < act_n);
   assign key_issue    = cmd.key_scan && !hit_ff && (32'(cnt_ff) < 32'(fill_ff));
   assign table_free   = 32'(fill_ff) < 32'(TABLE_ENTRIES);
   assign load_val     = lrd_vld_ff ? load_q : '0;

   assign load_rd_en   = load_issue || cmd.disc_read;
   assign load_rd_addr = cmd.disc_read ? hit_cpu_ff : cnt_ff[CW-1:0];
   assign load_wr_en   = cmd.charge || cmd.disc_write;
   assign load_wr_addr = cmd.charge ? best_ff : hit_cpu_ff;

   always_comb begin
      if (cmd.charge) begin
         if (best_load_ff[LOAD_W-1:0] == LOAD_MAX) begin
            load_wr_data = LOAD_MAX;
         end else begin
            load_wr_data = best_load_ff[LOAD_W-1:0] + LOAD_W'(1);
         end
      end else if (load_val == '0) begin
         load_wr_data = '0;
      end else begin
         load_wr_data = load_val - LOAD_W'(1);
      end
   end

   assign tbl_wr_en   = cmd.table_write && (hit_ff || table_free);
   assign tbl_wr_addr = hit_ff ? hit_idx_ff : fill_ff[TAW-1:0];

   assign best_wide    = 32'(best_ff);
   assign hit_cpu_wide = 32'(hit_cpu_ff);

   always_comb begin
      op_in         = op_ff;
      key_in        = key_ff;
      cnt_in        = cnt_ff;
      lrdv_in       = load_issue;
      lrd_vld_in    = lrd_vld_ff;
      lrd_idx_in    = lrd_idx_ff;
      krdv_in       = key_issue;
      krd_idx_in    = krd_idx_ff;
      best_in       = best_ff;
      best_load_in  = best_load_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      hit_cpu_in    = hit_cpu_ff;
      full_in       = full_ff;
      fill_in       = fill_ff;
      load_vld_in   = load_vld_ff;
      cpu_count_in  = cpu_count_ff;
      rsp_cpu_in    = rsp_cpu_ff;
      rsp_status_in = rsp_status_ff;

      if (csr_we) cpu_count_in = csr_data;

      if (load_rd_en) begin
         lrd_vld_in = load_vld_ff[load_rd_addr];
         lrd_idx_in = load_rd_addr;
      end
      if (load_wr_en) load_vld_in[load_wr_addr] = 1'b1;

      if (load_issue || key_issue) cnt_in = cnt_ff + CNT_W'(1);
      if (key_issue) krd_idx_in = cnt_ff[TAW-1:0];

      if (lrdv_ff && ({1'b0, load_val} < best_load_ff)) begin
         best_load_in = {1'b0, load_val};
         best_in      = lrd_idx_ff;
      end

      if (krdv_ff && !hit_ff && (tbl_q[KEY_W-1:0] == key_ff)) begin
         hit_in     = 1'b1;
         hit_idx_in = krd_idx_ff;
         hit_cpu_in = tbl_q[ENT_W-1:KEY_W];
      end

      if (cmd.charge) cnt_in = '0;

      if (cmd.table_write && !hit_ff) begin
         if (table_free) begin
            fill_in = fill_ff + FILL_W'(1);
         end else begin
            full_in = 1'b1;
         end
      end

      if (cmd.start) begin
         op_in        = req_op;
         key_in       = req_key;
         cnt_in       = '0;
         lrdv_in      = 1'b0;
         krdv_in      = 1'b0;
         best_in      = '0;
         best_load_in = {1'b1, {LOAD_W{1'b0}}};
         hit_in       = 1'b0;
         full_in      = 1'b0;
      end

      if (cmd.rsp_load) begin
         case (op_ff) inside
            OP_REGISTER: begin
               rsp_cpu_in    = best_wide[OUT_CPU_W-1:0];
               rsp_status_in = full_ff ? ST_FULL : ST_OK;
            end
            OP_LOOKUP, OP_UNREGISTER: begin
               rsp_cpu_in    = hit_ff ? hit_cpu_wide[OUT_CPU_W-1:0] : '0;
               rsp_status_in = hit_ff ? ST_OK : ST_NOT_FOUND;
            end
            default: begin
               rsp_cpu_in    = '0;
               rsp_status_in = ST_NOT_FOUND;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      lrd_vld_ff    <= lrd_vld_in;
      lrd_idx_ff    <= lrd_idx_in;
      krd_idx_ff    <= krd_idx_in;
      best_ff       <= best_in;
      best_load_ff  <= best_load_in;
      hit_idx_ff    <= hit_idx_in;
      hit_cpu_ff    <= hit_cpu_in;
      rsp_cpu_ff    <= rsp_cpu_in;
      rsp_status_ff <= rsp_status_in;
      if (reset) begin
         cnt_ff       <= '0;
         lrdv_ff      <= 1'b0;
         krdv_ff      <= 1'b0;
         hit_ff       <= 1'b0;
         full_ff      <= 1'b0;
         fill_ff      <= '0;
         cpu_count_ff <= CPU_COUNT_RESET;
         for (int i = 0; i < MAX_CPUS; i++) begin
            load_vld_ff[i] <= 1'b0;
         end
      end else begin
         cnt_ff       <= cnt_in;
         lrdv_ff      <= lrdv_in;
         krdv_ff      <= krdv_in;
         hit_ff       <= hit_in;
         full_ff      <= full_in;
         fill_ff      <= fill_in;
         cpu_count_ff <= cpu_count_in;
         load_vld_ff  <= load_vld_in;
      end
   end

   fclm_ram #(
      .WIDTH (LOAD_W),
      .DEPTH (MAX_CPUS)
   ) u_load_ram (
      .clock   (clock),
      .wr_en   (load_wr_en),
      .wr_addr (load_wr_addr),
      .wr_data (load_wr_data),
      .rd_en   (load_rd_en),
      .rd_addr (load_rd_addr),
      .rd_data (load_q)
   );

   fclm_ram #(
      .WIDTH (ENT_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_table_ram (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (tbl_wr_addr),
      .wr_data ({best_ff, key_ff}),
      .rd_en   (key_issue),
      .rd_addr (cnt_ff[TAW-1:0]),
      .rd_data (tbl_q)
   );

   assign sts.load_done = !lrdv_ff && (cnt_ff >= act_n);
   assign sts.key_done  = !krdv_ff && (hit_ff || (32'(cnt_ff) >= 32'(fill_ff)));
   assign sts.hit       = hit_ff;
   assign sts.op        = op_ff;

   assign rsp_cpu    = rsp_cpu_ff;
   assign rsp_status = rsp_status_ff;

endmodule

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the flow-to-CPU least-loaded mapper. A predictor
// holds its own copy of the flow table, the per-CPU loads and cpu_count, and
// works out the cpu and status of every accepted item. Each result is
// compared with the oldest outstanding prediction. Stimulus runs a directed
// pass over the special cases, then random phases under different idling,
// cpu_count settings, a long receiver hold-off and a table-fill phase.
// ----------------------------------------------------------------------------
module tb;
   import fclm_pkg::*;

   localparam int                TBL_N          = TABLE_ENTRIES_DEF;
   localparam int                CPU_N          = MAX_CPUS_DEF;
   localparam int                WATCHDOG_LIMIT = 5000;
   localparam int                POOL_N         = 128;
   localparam logic [OP_W-1:0]   OP_RESERVED    = 2'd3;

   typedef struct packed {
      logic [OUT_CPU_W-1:0] cpu;
      logic [STATUS_W-1:0]  status;
   } flow_result_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CFG_W-1:0]      csr_data   = '0;

   // predictor state
   logic                 tbl_valid [TBL_N];
   logic [KEY_W-1:0]     tbl_key   [TBL_N];
   logic [OUT_CPU_W-1:0] tbl_cpu   [TBL_N];
   logic [LOAD_W-1:0]    load      [CPU_N];
   logic [CFG_W-1:0]     cpu_count_q;

   flow_result_type  pending_maps[$];
   logic [KEY_W-1:0] key_pool[POOL_N];

   int src_idle_pct  = 0;
   int rsp_stall_pct = 0;
   int hold_req_len  = 0;
   int hold_req_id   = 0;
   int hold_seen_id  = 0;
   int hold_left     = 0;
   int idle_cycles   = 0;
   int errors        = 0;
   int items_sent    = 0;
   int n_ok          = 0;
   int n_not_found   = 0;
   int n_full        = 0;
   int cfg_writes    = 0;

   flow_to_cpu_least_loaded_mapper i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int find_flow(logic [KEY_W-1:0] key);
      for (int i = 0; i < TBL_N; i++)
         if (tbl_valid[i] && tbl_key[i] == key) return i;
      return -1;
   endfunction

   function automatic int find_free_slot();
      for (int i = 0; i < TBL_N; i++)
         if (!tbl_valid[i]) return i;
      return -1;
   endfunction

   function automatic flow_result_type map_flow(logic [OP_W-1:0] op, logic [KEY_W-1:0] key);
      flow_result_type r;
      int              n;
      int              best;
      int              idx;
      logic [16:0]     best_load;
      r.cpu    = '0;
      r.status = ST_NOT_FOUND;
      if (op == OP_REGISTER) begin
         n = (cpu_count_q == 0) ? 1 : ((cpu_count_q > CPU_N) ? CPU_N : int'(cpu_count_q));
         best      = 0;
         best_load = 17'h10000;
         for (int i = 0; i < n; i++) begin
            if ({1'b0, load[i]} < best_load) begin
               best_load = {1'b0, load[i]};
               best      = i;
            end
         end
         if (load[best] != LOAD_MAX) load[best] = load[best] + 1'b1;
         r.cpu = best[OUT_CPU_W-1:0];
         idx   = find_flow(key);
         if (idx < 0) idx = find_free_slot();
         if (idx < 0) begin
            r.status = ST_FULL;
         end else begin
            tbl_valid[idx] = 1'b1;
            tbl_key[idx]   = key;
            tbl_cpu[idx]   = r.cpu;
            r.status       = ST_OK;
         end
      end else if (op == OP_LOOKUP || op == OP_UNREGISTER) begin
         idx = find_flow(key);
         if (idx >= 0) begin
            r.cpu    = tbl_cpu[idx];
            r.status = ST_OK;
            if (op == OP_UNREGISTER && load[r.cpu] != 0) load[r.cpu] = load[r.cpu] - 1'b1;
         end
      end
      return r;
   endfunction

   // receiver: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (hold_req_id != hold_seen_id) begin
         hold_seen_id = hold_req_id;
         hold_left    = hold_req_len;
      end
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   // result check and watchdog
   always @(posedge clock) begin
      flow_result_type want;
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_maps.size() == 0) begin
            $error("result with no item outstanding: tdata %0h", rsp_tdata);
            errors++;
         end else begin
            want = pending_maps.pop_front();
            if (rsp_tdata[3:0] !== want.cpu) begin
               $error("cpu mismatch: expected %0d, got %0d", want.cpu, rsp_tdata[3:0]);
               errors++;
            end
            if (rsp_tdata[5:4] !== want.status) begin
               $error("status mismatch: expected %0d, got %0d", want.status, rsp_tdata[5:4]);
               errors++;
            end
         end
      end
   end

   task automatic offer_flow_item(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key);
      int              gap;
      flow_result_type r;
      gap = 0;
      while (gap < 30 && $urandom_range(0, 99) < src_idle_pct) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b0, key, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      r = map_flow(op, key);
      pending_maps.push_back(r);
      items_sent++;
      case (r.status)
         ST_OK:        n_ok++;
         ST_NOT_FOUND: n_not_found++;
         default:      n_full++;
      endcase
   endtask

   task automatic pause_until_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_maps.size() != 0) @(posedge clock);
   endtask

   task automatic set_cpu_count(input logic [CFG_W-1:0] value);
      pause_until_drained();
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid   <= 1'b0;
      cpu_count_q = value;
      cfg_writes++;
   endtask

   task automatic set_idling(input int src_pct, input int dst_pct);
      src_idle_pct  = src_pct;
      rsp_stall_pct = dst_pct;
   endtask

   task automatic run_random(input int count, input int pool_size, input bit fresh_keys);
      logic [OP_W-1:0]  op;
      logic [KEY_W-1:0] key;
      int               r;
      for (int k = 0; k < count; k++) begin
         r = $urandom_range(0, 99);
         if (r < 5)       op = OP_RESERVED;
         else if (r < 45) op = OP_REGISTER;
         else if (r < 78) op = OP_LOOKUP;
         else             op = OP_UNREGISTER;
         if ($urandom_range(0, 9) == 0 && (fresh_keys || op != OP_REGISTER))
            key = $urandom;
         else
            key = key_pool[$urandom_range(0, pool_size - 1)];
         offer_flow_item(op, key);
      end
   endtask

   task automatic test_directed();
      set_idling(0, 0);
      offer_flow_item(OP_LOOKUP, 16'h0000);
      offer_flow_item(OP_UNREGISTER, 16'hFFFF);
      offer_flow_item(OP_RESERVED, 16'hFFFF);
      offer_flow_item(OP_REGISTER, 16'h0000);
      offer_flow_item(OP_REGISTER, 16'hFFFF);
      offer_flow_item(OP_LOOKUP, 16'h0000);
      offer_flow_item(OP_LOOKUP, 16'hFFFF);
      offer_flow_item(OP_UNREGISTER, 16'h0000);
      offer_flow_item(OP_UNREGISTER, 16'hFFFF);
      // load is zero now: discharge must saturate
      offer_flow_item(OP_UNREGISTER, 16'h0000);
      offer_flow_item(OP_LOOKUP, 16'h0000);
      set_cpu_count(5'd0);
      offer_flow_item(OP_REGISTER, 16'h1234);
      set_cpu_count(5'd31);
      offer_flow_item(OP_REGISTER, 16'h5555);
      offer_flow_item(OP_REGISTER, 16'hAAAA);
      offer_flow_item(OP_REGISTER, 16'h00FF);
      offer_flow_item(OP_REGISTER, 16'hFF00);
      // reassign an existing key to a new CPU
      offer_flow_item(OP_REGISTER, 16'h0000);
      offer_flow_item(OP_LOOKUP, 16'h0000);
      offer_flow_item(OP_UNREGISTER, 16'h0000);
      offer_flow_item(OP_RESERVED, 16'h0000);
      pause_until_drained();
   endtask

   task automatic test_no_idling();
      set_cpu_count(5'd16);
      set_idling(0, 0);
      run_random(350, 40, 1'b0);
   endtask

   task automatic test_sender_idle();
      set_cpu_count(5'd1);
      set_idling(68, 0);
      run_random(350, 40, 1'b0);
   endtask

   task automatic test_receiver_stall();
      set_cpu_count(5'd31);
      set_idling(0, 68);
      run_random(350, 40, 1'b0);
   endtask

   task automatic test_both_idle();
      set_cpu_count(5'd7);
      set_idling(25, 25);
      run_random(350, 40, 1'b0);
   endtask

   task automatic test_backpressure();
      set_cpu_count(5'($urandom_range(2, 16)));
      set_idling(0, 0);
      hold_req_len = 400;
      hold_req_id++;
      run_random(40, 40, 1'b0);
      pause_until_drained();
   endtask

   task automatic test_table_fill();
      set_cpu_count(5'($urandom_range(1, 16)));
      set_idling(25, 25);
      run_random(450, POOL_N, 1'b1);
   endtask

   task automatic test_mixed_settings();
      int mode;
      for (int k = 0; k < 4; k++) begin
         set_cpu_count(5'($urandom_range(0, 31)));
         mode = $urandom_range(0, 3);
         case (mode)
            0:       set_idling(0, 0);
            1:       set_idling(68, 0);
            2:       set_idling(0, 68);
            default: set_idling(25, 25);
         endcase
         run_random(60, POOL_N, 1'b1);
      end
   endtask

   initial begin
      for (int i = 0; i < TBL_N; i++) begin
         tbl_valid[i] = 1'b0;
         tbl_key[i]   = '0;
         tbl_cpu[i]   = '0;
      end
      for (int i = 0; i < CPU_N; i++) load[i] = '0;
      cpu_count_q = CPU_COUNT_RESET;
      key_pool[0] = 16'h0000;
      key_pool[1] = 16'hFFFF;
      for (int i = 2; i < POOL_N; i++) key_pool[i] = $urandom;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_no_idling();
      test_sender_idle();
      test_receiver_stall();
      test_both_idle();
      test_backpressure();
      test_table_fill();
      test_mixed_settings();

      pause_until_drained();
      repeat (100) @(posedge clock);
      $display("Ran %0d items over %0d cpu_count writes, with idle and stall phases",
               items_sent, cfg_writes);
      $display("Outcomes: %0d ok, %0d not found, %0d table full",
               n_ok, n_not_found, n_full);
      if (errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
